// ----- hw/rtl/prescaled_interval_timer_macros.svh -----
// Assertion macros shared by the prescaled interval timer RTL.
// Plain text macros only; no dependencies.
`ifndef PRESCALED_INTERVAL_TIMER_MACROS_SVH
`define PRESCALED_INTERVAL_TIMER_MACROS_SVH

// Check that prop holds in the same cycle whenever cond holds.
`define PIT_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("pit: same-cycle check failed");

// Check that prop holds in the cycle after cond holds.
`define PIT_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("pit: next-cycle check failed");

`endif

// ----- hw/rtl/pit_pkg.sv -----
// Shared types, codes and helpers of the prescaled interval timer.
// No dependencies.
package pit_pkg;

    // Item kinds (carried on the input tuser)
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Byte register offsets
    localparam logic [2:0] OFF_INTV_LO = 3'd0;
    localparam logic [2:0] OFF_INTV_HI = 3'd1;
    localparam logic [2:0] OFF_CNT_LO  = 3'd2;
    localparam logic [2:0] OFF_CNT_HI  = 3'd3;
    localparam logic [2:0] OFF_CTRL0   = 3'd4;
    localparam logic [2:0] OFF_RUN     = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] reg_offset;
        logic [7:0] write_byte;
    } pit_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       interrupt_pulse;
    } pit_result_t;

    // Prescale divisor 2^n, n in 0..7
    function automatic logic [8:0] pit_divisor(input logic [2:0] exp_sel);
        pit_divisor = 9'd1 << exp_sel;
    endfunction

endpackage

// ----- hw/rtl/prescaled_interval_timer.sv -----
// Prescaled 16-bit interval timer: one word in per cycle while the output is not stalled,
// one result word out per word in. The input word carries a tick, a byte read or a byte
// write of one of six registers (interval lo/hi, counter lo/hi, control0, run). Each word
// is latched in an input register, handled by pit_core once the output register is free,
// and its result is registered in the output register that drives m_tdata. A new word is
// taken every cycle while results are drained; only a stalled output register holds the
// input side.
// Reset clears valid flags and timer state; prescale divisor is then one, timer stopped.
// Depends on pit_pkg and pit_core.
module prescaled_interval_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] reg_offset, [10:3] write_byte, [15:11] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_byte, [8] interrupt_pulse, [15:9] zero
);
    import pit_pkg::*;

    logic        in_valid_reg, in_valid_next;
    pit_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    pit_result_t out_result_reg;
    pit_result_t core_result;
    logic        out_free;
    logic        proc_en;
    logic        in_take;

    assign out_free = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (proc_en) begin
            in_valid_next = 1'b0;
        end
        if (proc_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.op         <= s_tuser;
            in_item_reg.reg_offset <= s_tdata[2:0];
            in_item_reg.write_byte <= s_tdata[10:3];
        end
        if (proc_en) begin
            out_result_reg <= core_result;
        end
    end

    pit_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc_en (proc_en),
        .item    (in_item_reg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg.interrupt_pulse, out_result_reg.read_byte};

endmodule

// ----- hw/rtl/pit_core.sv -----
// Timer state (interval, counter, control0, run, prescaler) and per-word logic.
// Depends on pit_pkg and prescaled_interval_timer_macros.svh.
`include "prescaled_interval_timer_macros.svh"

module pit_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 proc_en,
    input  pit_pkg::pit_item_t   item,
    output pit_pkg::pit_result_t result
);
    import pit_pkg::*;

    logic [15:0] interval_reg, interval_next;
    logic [15:0] count_reg, count_next;
    logic [3:0]  ctrl_reg, ctrl_next;
    logic        run_reg, run_next;
    logic [7:0]  prescale_reg, prescale_next;

    logic [8:0]  divisor;
    logic [8:0]  prescale_inc;
    logic [15:0] count_inc;
    logic        prescale_wrap;

    assign divisor       = pit_divisor(ctrl_reg[2:0]);
    assign prescale_inc  = {1'b0, prescale_reg} + 9'd1;
    assign count_inc     = count_reg + 16'd1;
    assign prescale_wrap = (prescale_inc >= divisor);

    always_comb begin
        interval_next          = interval_reg;
        count_next             = count_reg;
        ctrl_next              = ctrl_reg;
        run_next               = run_reg;
        prescale_next          = prescale_reg;
        result.read_byte       = 8'd0;
        result.interrupt_pulse = 1'b0;
        case (item.op)
            OP_TICK: begin
                if (run_reg) begin
                    if (!prescale_wrap) begin
                        prescale_next = prescale_inc[7:0];
                    end else begin
                        prescale_next = 8'd0;
                        if (interval_reg == 16'd0) begin
                            count_next = 16'd0;
                        end else if (count_inc >= interval_reg) begin
                            count_next             = 16'd0;
                            result.interrupt_pulse = 1'b1;
                        end else begin
                            count_next = count_inc;
                        end
                    end
                end
            end
            OP_READ: begin
                case (item.reg_offset)
                    OFF_INTV_LO: result.read_byte = interval_reg[7:0];
                    OFF_INTV_HI: result.read_byte = interval_reg[15:8];
                    OFF_CNT_LO:  result.read_byte = count_reg[7:0];
                    OFF_CNT_HI:  result.read_byte = count_reg[15:8];
                    OFF_CTRL0:   result.read_byte = {4'd0, ctrl_reg};
                    OFF_RUN:     result.read_byte = {7'd0, run_reg};
                    default:     result.read_byte = 8'd0;
                endcase
            end
            OP_WRITE: begin
                case (item.reg_offset)
                    OFF_INTV_LO: interval_next = {interval_reg[15:8], item.write_byte};
                    OFF_INTV_HI: interval_next = {item.write_byte, interval_reg[7:0]};
                    // either counter byte clears the whole counter
                    OFF_CNT_LO, OFF_CNT_HI: count_next = 16'd0;
                    OFF_CTRL0:   ctrl_next = item.write_byte[3:0];
                    OFF_RUN:     run_next  = item.write_byte[0];
                    default:     ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= 16'd0;
            count_reg    <= 16'd0;
            ctrl_reg     <= 4'd0;
            run_reg      <= 1'b0;
            prescale_reg <= 8'd0;
        end else if (proc_en) begin
            interval_reg <= interval_next;
            count_reg    <= count_next;
            ctrl_reg     <= ctrl_next;
            run_reg      <= run_next;
            prescale_reg <= prescale_next;
        end
    end

    `PIT_ASSERT_NOW(a_pulse_only_on_tick, aclk, aresetn, result.interrupt_pulse, item.op == OP_TICK && run_reg && prescale_wrap)
    `PIT_ASSERT_NOW(a_read_zero_otherwise, aclk, aresetn, item.op != OP_READ, result.read_byte == 8'd0)
    `PIT_ASSERT_NEXT(a_prescale_below_div, aclk, aresetn, proc_en && item.op == OP_TICK && run_reg, {1'b0, prescale_reg} < pit_divisor(ctrl_reg[2:0]))
    `PIT_ASSERT_NEXT(a_zero_interval_hold, aclk, aresetn, proc_en && item.op == OP_TICK && run_reg && prescale_wrap && interval_reg == 16'd0, count_reg == 16'd0)

endmodule

// ----- dv/timer_result_checker.sv -----
// Result checker for prescaled_interval_timer: watches both stream channels,
// predicts every result word and compares it with what the block returns.
// Depends on pit_pkg for the item and result types and the register codes.
module timer_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] reg_offset, [10:3] write_byte, [15:11] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] read_byte, [8] interrupt_pulse, [15:9] zero
    output int unsigned mismatch_count,
    output int unsigned pending_words,
    output int unsigned word_count,
    output int unsigned tick_count,
    output int unsigned pulse_count,
    output int unsigned read_count
);
    import pit_pkg::*;

    localparam int unsigned REPORT_MAX = 10;

    // predicted timer state
    logic [15:0] interval_reg;
    logic [15:0] counter_reg;
    logic [3:0]  control_reg;
    logic        run_reg;
    logic [7:0]  prescaler;

    pit_result_t timer_replies[$];
    int unsigned errors;
    int unsigned words_in;
    int unsigned ticks_in;
    int unsigned pulses_out;
    int unsigned reads_in;

    initial begin
        mismatch_count = 0;
        pending_words  = 0;
        word_count     = 0;
        tick_count     = 0;
        pulse_count    = 0;
        read_count     = 0;
        errors         = 0;
        words_in       = 0;
        ticks_in       = 0;
        pulses_out     = 0;
        reads_in       = 0;
    end

    // Apply one word to the predicted state and return the reply it earns.
    function automatic pit_result_t timer_step(input pit_item_t w);
        pit_result_t r;
        logic [8:0]  divisor;
        logic [8:0]  pre_next;
        logic [15:0] cnt_next;
        r = '0;
        case (w.op)
            OP_TICK: begin
                if (run_reg) begin
                    divisor  = 9'd1 << control_reg[2:0];
                    pre_next = {1'b0, prescaler} + 9'd1;
                    if (pre_next < divisor) begin
                        prescaler = pre_next[7:0];
                    end else begin
                        prescaler = 8'd0;
                        cnt_next  = counter_reg + 16'd1;
                        if (interval_reg == 16'd0) begin
                            counter_reg = 16'd0;
                        end else if (cnt_next >= interval_reg) begin
                            // also catches an interval lowered below the counter
                            counter_reg = 16'd0;
                            r.interrupt_pulse = 1'b1;
                        end else begin
                            counter_reg = cnt_next;
                        end
                    end
                end
            end
            OP_READ: begin
                case (w.reg_offset)
                    OFF_INTV_LO: r.read_byte = interval_reg[7:0];
                    OFF_INTV_HI: r.read_byte = interval_reg[15:8];
                    OFF_CNT_LO:  r.read_byte = counter_reg[7:0];
                    OFF_CNT_HI:  r.read_byte = counter_reg[15:8];
                    OFF_CTRL0:   r.read_byte = {4'd0, control_reg};
                    OFF_RUN:     r.read_byte = {7'd0, run_reg};
                    default:     r.read_byte = 8'd0;
                endcase
            end
            OP_WRITE: begin
                case (w.reg_offset)
                    OFF_INTV_LO: interval_reg[7:0]  = w.write_byte;
                    OFF_INTV_HI: interval_reg[15:8] = w.write_byte;
                    OFF_CNT_LO,
                    OFF_CNT_HI:  counter_reg = 16'd0;
                    OFF_CTRL0:   control_reg = w.write_byte[3:0];
                    OFF_RUN:     run_reg     = w.write_byte[0];
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        pit_item_t   word;
        pit_result_t want;
        pit_result_t got;
        if (!aresetn) begin
            interval_reg = 16'd0;
            counter_reg  = 16'd0;
            control_reg  = 4'd0;
            run_reg      = 1'b0;
            prescaler    = 8'd0;
            timer_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_byte       = m_tdata[7:0];
                got.interrupt_pulse = m_tdata[8];
                if (got.interrupt_pulse)
                    pulses_out++;
                if (timer_replies.size() == 0) begin
                    if (errors < REPORT_MAX)
                        $display("%0t: unexpected result word: read_byte %02h pulse %0b",
                                 $realtime, got.read_byte, got.interrupt_pulse);
                    errors++;
                end else begin
                    want = timer_replies.pop_front();
                    if (got.read_byte != want.read_byte ||
                        got.interrupt_pulse != want.interrupt_pulse) begin
                        if (errors < REPORT_MAX)
                            $display("%0t: mismatch: read_byte exp %02h got %02h, pulse exp %0b got %0b",
                                     $realtime, want.read_byte, got.read_byte,
                                     want.interrupt_pulse, got.interrupt_pulse);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                word.op         = s_tuser;
                word.reg_offset = s_tdata[2:0];
                word.write_byte = s_tdata[10:3];
                words_in++;
                if (word.op == OP_TICK)
                    ticks_in++;
                if (word.op == OP_READ)
                    reads_in++;
                timer_replies.push_back(timer_step(word));
            end
        end
        mismatch_count <= errors;
        pending_words  <= timer_replies.size();
        word_count     <= words_in;
        tick_count     <= ticks_in;
        pulse_count    <= pulses_out;
        read_count     <= reads_in;
    end

endmodule

// ----- dv/tb_top.sv -----
// Top of the prescaled_interval_timer testbench: clock, reset, stimulus and verdict.
// Drives directed and random words through four idle/stall phases; timer_result_checker
// does the prediction and comparison. Depends on pit_pkg and timer_result_checker.
module tb_top;
    import pit_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam logic [2:0] OFF_SPARE6  = 3'd6;
    localparam logic [2:0] OFF_SPARE7  = 3'd7;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_WORDS = 180;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;   // [2:0] reg_offset, [10:3] write_byte, [15:11] zero
    logic [1:0]  s_tuser  = 2'd0;    // [1:0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] read_byte, [8] interrupt_pulse, [15:9] zero

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned mismatch_count;
    int unsigned pending_words;
    int unsigned word_count;
    int unsigned tick_count;
    int unsigned pulse_count;
    int unsigned read_count;

    always #5 aclk = ~aclk;

    prescaled_interval_timer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    timer_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words),
        .word_count     (word_count),
        .tick_count     (tick_count),
        .pulse_count    (pulse_count),
        .read_count     (read_count)
    );

    // result side: stall at random, one decision per cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic pit_item_t make_word(input logic [1:0] op, input logic [2:0] off,
                                            input logic [7:0] data);
        pit_item_t w;
        w.op         = op;
        w.reg_offset = off;
        w.write_byte = data;
        return w;
    endfunction

    // Mostly ticks against small intervals and divisors, so pulses come often.
    function automatic pit_item_t random_word();
        pit_item_t   w;
        int unsigned pick;
        logic [7:0]  d;
        d            = 8'($urandom);
        w.write_byte = d;
        w.reg_offset = 3'($urandom_range(7));
        pick         = $urandom_range(99);
        if (pick < 55) begin
            w.op = OP_TICK;
        end else if (pick < 70) begin
            w.op = OP_READ;
        end else if (pick < 95) begin
            w.op = OP_WRITE;
            case ($urandom_range(11))
                0, 1, 2: begin
                    w.reg_offset = OFF_INTV_LO;
                    if ($urandom_range(9) < 7)
                        w.write_byte = 8'($urandom_range(1, 12));
                end
                3: begin
                    w.reg_offset = OFF_INTV_HI;
                    if ($urandom_range(99) < 85)
                        w.write_byte = 8'd0;
                end
                4: w.reg_offset = OFF_CNT_LO;
                5: w.reg_offset = OFF_CNT_HI;
                6, 7: begin
                    w.reg_offset = OFF_CTRL0;
                    if ($urandom_range(9) < 7)
                        w.write_byte[2:0] = 3'($urandom_range(2));
                end
                8, 9: begin
                    w.reg_offset    = OFF_RUN;
                    w.write_byte[0] = ($urandom_range(99) < 85);
                end
                10: w.reg_offset = OFF_SPARE6;
                default: w.reg_offset = OFF_SPARE7;
            endcase
        end else begin
            w.op = OP_SPARE;
        end
        return w;
    endfunction

    // Offer one word, idling first at random; return once it is taken.
    task automatic send_word(input pit_item_t w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, w.write_byte, w.reg_offset};
        s_tuser  <= w.op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_directed();
        send_word(make_word(OP_TICK, OFF_INTV_LO, 8'h00));     // tick while stopped
        send_word(make_word(OP_SPARE, OFF_SPARE7, 8'hFF));
        send_word(make_word(OP_WRITE, OFF_SPARE6, 8'hFF));
        send_word(make_word(OP_READ, OFF_SPARE7, 8'h00));
        send_word(make_word(OP_WRITE, OFF_INTV_LO, 8'h03));
        send_word(make_word(OP_WRITE, OFF_INTV_HI, 8'h00));
        send_word(make_word(OP_WRITE, OFF_CTRL0, 8'hFF));      // divisor 128, bit 3 set
        send_word(make_word(OP_READ, OFF_CTRL0, 8'h00));
        send_word(make_word(OP_WRITE, OFF_RUN, 8'hFF));
        send_word(make_word(OP_READ, OFF_RUN, 8'h00));
        repeat (3)
            send_word(make_word(OP_TICK, OFF_RUN, 8'h00));
        // drop the divisor below the prescaler
        send_word(make_word(OP_WRITE, OFF_CTRL0, 8'h01));
        send_word(make_word(OP_TICK, OFF_RUN, 8'h00));
        send_word(make_word(OP_WRITE, OFF_CTRL0, 8'hF0));
        repeat (4)
            send_word(make_word(OP_TICK, OFF_RUN, 8'h00));
        // drop the interval below the counter
        send_word(make_word(OP_WRITE, OFF_INTV_LO, 8'h01));
        send_word(make_word(OP_TICK, OFF_RUN, 8'h00));
        // zero interval holds the counter
        send_word(make_word(OP_WRITE, OFF_INTV_LO, 8'h00));
        send_word(make_word(OP_TICK, OFF_RUN, 8'h00));
        send_word(make_word(OP_WRITE, OFF_CNT_HI, 8'h5A));
        send_word(make_word(OP_WRITE, OFF_INTV_HI, 8'hFF));
        send_word(make_word(OP_WRITE, OFF_INTV_LO, 8'hFF));
        send_word(make_word(OP_READ, OFF_INTV_HI, 8'h00));
        send_word(make_word(OP_READ, OFF_CNT_LO, 8'h00));
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_word(random_word());
    endtask

    // watchdog: end the run once nothing moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (6)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no idling
        src_idle_pct    = 0;
        sink_stall_pct <= 0;
        send_directed();
        send_random(PHASE_WORDS);

        // sender idles
        src_idle_pct    = 77;
        sink_stall_pct <= 0;
        send_random(PHASE_WORDS);

        // receiver stalls
        src_idle_pct    = 0;
        sink_stall_pct <= 77;
        send_random(PHASE_WORDS);

        // both, lightly
        src_idle_pct    = 14;
        sink_stall_pct <= 14;
        send_random(PHASE_WORDS + 5);

        s_tvalid <= 1'b0;
        // let the checker count the last word before waiting for the drain
        @(posedge aclk);
        while (pending_words != 0)
            @(posedge aclk);
        repeat (8)
            @(posedge aclk);

        $display("covered %0d words over four idle/stall phases: %0d ticks, %0d reads,",
                 word_count, tick_count, read_count);
        $display("%0d interrupt pulses, %0d mismatching result words", pulse_count,
                 mismatch_count);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pit_pkg.sv
hw/rtl/pit_core.sv
hw/rtl/prescaled_interval_timer.sv
dv/timer_result_checker.sv
dv/tb_top.sv
